>>> design/ssid_pkg.sv
// ----------------------------------------------------------------------------
// ssid_pkg: shared types, constants and character maps
// Payload structs and the two character code maps of the short string
// identifier encoder.
// ----------------------------------------------------------------------------
package ssid_pkg;

  localparam int unsigned HeaderSize = 4;
  localparam int unsigned FiveMaxChars = 12;
  localparam int unsigned SixMaxChars = 10;
  localparam int unsigned FiveBits = 5;
  localparam int unsigned SixBits = 6;
  localparam int unsigned IdWidth = 64;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned ShiftWidth = 6;

  localparam logic [CountWidth-1:0] CountSat = '1;
  localparam logic [IdWidth-1:0] FiveHeader = IdWidth'(0);
  localparam logic [IdWidth-1:0] SixHeader = IdWidth'(1);

  localparam logic [4:0] FiveDash = 5'd27;
  localparam logic [4:0] FiveTwo = 5'd28;
  localparam logic [4:0] FiveFive = 5'd29;
  localparam logic [4:0] FiveSix = 5'd30;
  localparam logic [5:0] SixDash = 6'd27;
  localparam logic [5:0] SixDigitBase = 6'd28;
  localparam logic [5:0] SixUpperBase = 6'd38;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } ssid_in_t;

  typedef struct packed {
    logic [IdWidth-1:0] packed_id;
    logic               status;
  } ssid_out_t;

  // 5-bit code of a byte; zero means the byte is outside the charset.
  function automatic logic [4:0] code_five(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h61;
    if (c >= 8'h61 && c <= 8'h7a) return d[4:0] + 5'd1;
    else if (c == 8'h2d) return FiveDash;
    else if (c == 8'h32) return FiveTwo;
    else if (c == 8'h35) return FiveFive;
    else if (c == 8'h36) return FiveSix;
    else return 5'd0;
  endfunction

  // 6-bit code of a byte; zero means the byte is outside the charset.
  function automatic logic [5:0] code_six(input logic [7:0] c);
    logic [7:0] dl;
    logic [7:0] dd;
    logic [7:0] du;
    dl = c - 8'h61;
    dd = c - 8'h30;
    du = c - 8'h41;
    if (c >= 8'h61 && c <= 8'h7a) return {1'b0, dl[4:0]} + 6'd1;
    else if (c == 8'h2d) return SixDash;
    else if (c >= 8'h30 && c <= 8'h39) return {2'b0, dd[3:0]} + SixDigitBase;
    else if (c >= 8'h41 && c <= 8'h5a) return {1'b0, du[4:0]} + SixUpperBase;
    else return 6'd0;
  endfunction

endpackage

>>> design/short_string_id_encoder.sv
// ----------------------------------------------------------------------------
// short_string_id_encoder: packs a short string into a 64-bit identifier
// The block takes one byte per transfer, first character first, and builds
// a 5-bit packing (a-z, '-', '2', '5', '6', up to 12 characters, header 0)
// and a 6-bit packing (a-z, '-', 0-9, A-Z, up to 10 characters, header 1)
// side by side. On the byte marked last it returns one identifier: the
// 5-bit packing if valid, else the 6-bit one, else id 0 with status 1.
// One byte is taken every cycle; the result for the last byte is registered
// into the output register, or into the skid entry while a stalled result
// holds it. This two-entry output buffer lets the input keep flowing while a
// result waits, and the input stalls only when both entries are full.
// ----------------------------------------------------------------------------
module short_string_id_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  ssid_pkg::ssid_in_t char_data,
  output logic               id_valid,
  input  logic               id_stall,
  output ssid_pkg::ssid_out_t id_data
);
  import ssid_pkg::*;

  logic [IdWidth-1:0]    acc_five;
  logic [IdWidth-1:0]    acc_six;
  logic                  five_ok;
  logic                  six_ok;
  logic [CountWidth-1:0] char_count;
  logic                  skid_valid;
  ssid_out_t             skid_data;

  logic                  char_accept;
  logic                  id_take;
  logic [4:0]            code5;
  logic [5:0]            code6;
  logic [ShiftWidth-1:0] shift5;
  logic [ShiftWidth-1:0] shift6;
  logic                  five_ok_next;
  logic                  six_ok_next;
  logic [IdWidth-1:0]    acc_five_next;
  logic [IdWidth-1:0]    acc_six_next;
  logic                  result_valid;
  ssid_out_t             result;

  assign char_stall  = skid_valid;
  assign char_accept = char_valid && !char_stall;
  assign id_take     = id_valid && !id_stall;

  assign code5  = code_five(char_data.char_byte);
  assign code6  = code_six(char_data.char_byte);
  assign shift5 = ShiftWidth'(HeaderSize) +
                  ShiftWidth'({2'b00, char_count}) * ShiftWidth'(FiveBits);
  assign shift6 = ShiftWidth'(HeaderSize) +
                  ShiftWidth'({2'b00, char_count}) * ShiftWidth'(SixBits);

  always_comb begin
    five_ok_next  = five_ok;
    six_ok_next   = six_ok;
    acc_five_next = acc_five;
    acc_six_next  = acc_six;
    if (char_count >= CountWidth'(FiveMaxChars) || code5 == 5'd0) begin
      five_ok_next = 1'b0;
    end else begin
      acc_five_next = acc_five | (IdWidth'(code5) << shift5);
    end
    if (char_count >= CountWidth'(SixMaxChars) || code6 == 6'd0) begin
      six_ok_next = 1'b0;
    end else begin
      acc_six_next = acc_six | (IdWidth'(code6) << shift6);
    end

    result_valid = char_accept && char_data.last_char;
    priority if (five_ok_next) begin
      result.packed_id = acc_five_next;
      result.status    = STATUS_OK;
    end else if (six_ok_next) begin
      result.packed_id = acc_six_next;
      result.status    = STATUS_OK;
    end else begin
      result.packed_id = '0;
      result.status    = STATUS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_five   <= FiveHeader;
      acc_six    <= SixHeader;
      five_ok    <= 1'b1;
      six_ok     <= 1'b1;
      char_count <= '0;
    end else if (char_accept) begin
      if (char_data.last_char) begin
        acc_five   <= FiveHeader;
        acc_six    <= SixHeader;
        five_ok    <= 1'b1;
        six_ok     <= 1'b1;
        char_count <= '0;
      end else begin
        acc_five <= acc_five_next;
        acc_six  <= acc_six_next;
        five_ok  <= five_ok_next;
        six_ok   <= six_ok_next;
        if (char_count != CountSat) begin
          char_count <= char_count + CountWidth'(1);
        end
      end
    end
  end

  // The skid entry only fills while the output register holds a stalled
  // result; it drains into the output register on the next transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_valid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (id_take) begin
        skid_valid <= 1'b0;
      end
    end else if (!id_valid || id_take) begin
      id_valid <= result_valid;
    end else if (result_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (id_take) begin
        id_data <= skid_data;
      end
    end else if (!id_valid || id_take) begin
      if (result_valid) begin
        id_data <= result;
      end
    end else if (result_valid) begin
      skid_data <= result;
    end
  end

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> id_valid)
    else $error("skid entry full while output register is empty");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (id_valid && id_data.status == STATUS_INVALID) |-> id_data.packed_id == '0)
    else $error("invalid result carries a nonzero id");

  a_header_ok: assert property (@(posedge clk) disable iff (rst)
    (id_valid && id_data.status == STATUS_OK) |->
      (id_data.packed_id[3:0] == 4'd0 || id_data.packed_id[3:0] == 4'd1))
    else $error("valid result has a bad header nibble");

  a_string_restart: assert property (@(posedge clk) disable iff (rst)
    (char_accept && char_data.last_char) |=>
      (char_count == '0 && five_ok && six_ok && acc_six == SixHeader))
    else $error("state not restored after the last byte");

endmodule
